// ----- hw/rtl/dll_pkg.sv -----
// Shared types and constants of the doubly linked list engine.
`default_nettype none

package dll_pkg;

	// Default configuration of the node pool
	localparam int POOL_NODES_DEF = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Field widths on the stream ports
	localparam int ACTION_W    = 3;
	localparam int HANDLE_W    = 5;
	localparam int VALUE_W     = 32;
	localparam int RHANDLE_W   = 6;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;

	// Action codes carried in the input tuser
	typedef enum logic [ACTION_W-1:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_END   = 3'd1,
		ACT_INS_AFTER = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_END   = 3'd4,
		ACT_DEL_NODE  = 3'd5,
		ACT_TRAVERSE  = 3'd6
	} action_t;

	// Result status codes carried in the output tuser
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_EMPTY      = 2'd2,
		STAT_BAD_HANDLE = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/doubly_linked_list_engine_unit.sv -----
// Doubly linked list engine over a fixed node pool, driven by a small sequencer.
// An insert steps through DECIDE, WNEW, WLINK and REPORT before its result is loaded;
// a delete through DECIDE, UNLINK and REPORT, and a failed check or unused code through
// DECIDE and REPORT. Traverse repeats TCHECK and TEMIT, one result per node.
// Each node memory has one registered read and one write port. REPORT and TEMIT stall
// on a held output; the input is ready in the cycle after the last result is loaded.
// Asynchronous active-low reset empties the list; node memories are not cleared.
`default_nettype none

module doubly_linked_list_engine_unit #(
	parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
	parameter int VALUE_BITS = dll_pkg::VALUE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// tdata: node_handle[4:0], value[36:5], zero fill[39:37]
	input  wire logic [dll_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: action[2:0]
	input  wire logic [dll_pkg::ACTION_W-1:0]     s_axis_tuser,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata: result_handle[5:0], result_value[37:6], head_handle[43:38],
	//        tail_handle[49:44], node_count[55:50]
	output logic [dll_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// tuser: status[1:0]
	output logic [dll_pkg::STATUS_W-1:0]          m_axis_tuser,
	output logic                                  m_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready
);

	localparam int SLOT_W = $clog2(POOL_NODES);
	localparam int LINK_W = $clog2(POOL_NODES + 1);
	localparam int CMP_W  = (LINK_W > dll_pkg::HANDLE_W) ? LINK_W : dll_pkg::HANDLE_W;
	localparam int RH_W   = dll_pkg::RHANDLE_W;
	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_NODES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_WNEW,
		S_WLINK,
		S_UNLINK,
		S_REPORT,
		S_TCHECK,
		S_TEMIT
	} state_t;

	state_t                       state_q;
	dll_pkg::action_t             act_q;
	logic [dll_pkg::HANDLE_W-1:0] h_q;
	logic [dll_pkg::VALUE_W-1:0]  v_q;
	logic [CMP_W-1:0]             slot_q;
	logic [LINK_W-1:0]            link_q;
	logic [SLOT_W-1:0]            k_q;
	logic [POOL_NODES-1:0]        used_q;
	logic [LINK_W-1:0]            head_q;
	logic [LINK_W-1:0]            tail_q;
	logic [LINK_W-1:0]            count_q;
	logic [RH_W-1:0]              rep_handle_q;
	dll_pkg::status_t             rep_status_q;

	// Output register
	logic                         out_valid_q;
	logic [RH_W-1:0]              out_handle_q;
	logic [dll_pkg::VALUE_W-1:0]  out_value_q;
	dll_pkg::status_t             out_status_q;
	logic [RH_W-1:0]              out_head_q;
	logic [RH_W-1:0]              out_tail_q;
	logic [RH_W-1:0]              out_count_q;
	logic                         out_last_q;

	// Node memories
	logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
	logic [LINK_W-1:0]     nx_mem  [POOL_NODES];
	logic [LINK_W-1:0]     pv_mem  [POOL_NODES];
	logic [VALUE_BITS-1:0] vl_rd_q;
	logic [LINK_W-1:0]     nx_rd_q;
	logic [LINK_W-1:0]     pv_rd_q;

	logic                  vl_we, vl_re, nx_we, nx_re, pv_we, pv_re;
	logic [SLOT_W-1:0]     vl_addr, nx_wa, nx_ra, pv_wa, pv_ra;
	logic [VALUE_BITS-1:0] vl_wd;
	logic [LINK_W-1:0]     nx_wd, pv_wd;

	logic                  free_found;
	logic [SLOT_W-1:0]     free_slot;
	logic [CMP_W-1:0]      h_ext;
	logic [CMP_W-1:0]      sel_slot;
	logic [SLOT_W-1:0]     slot_idx;
	logic [LINK_W-1:0]     slot_link;
	logic                  list_empty;
	logic                  out_free;
	logic                  out_load;
	logic                  trav_fin;

	function automatic logic slot_live(input logic [CMP_W-1:0] s,
	                                   input logic [POOL_NODES-1:0] used);
		return (s < CMP_W'(POOL_NODES)) && used[s[SLOT_W-1:0]];
	endfunction

	dll_free_finder #(
		.POOL_NODES (POOL_NODES)
	) u_free (
		.clk    (clk),
		.arst_n (arst_n),
		.used   (used_q),
		.found  (free_found),
		.slot   (free_slot)
	);

	// Decode helpers
	assign h_ext      = CMP_W'(h_q);
	assign slot_idx   = slot_q[SLOT_W-1:0];
	assign slot_link  = LINK_W'(slot_q);
	assign list_empty = (count_q == '0) || (head_q >= NONE_LINK);
	assign out_free   = !out_valid_q || m_axis_tready;
	assign out_load   = ((state_q == S_REPORT) || (state_q == S_TEMIT)) && out_free;
	assign trav_fin   = (nx_rd_q >= NONE_LINK) || (k_q == SLOT_W'(POOL_NODES - 1));

	// Select the slot a delete acts on
	always_comb begin
		case (act_q)
			dll_pkg::ACT_DEL_FRONT: sel_slot = CMP_W'(head_q);
			dll_pkg::ACT_DEL_END:   sel_slot = CMP_W'(tail_q);
			default:                sel_slot = h_ext;
		endcase
	end

	// Drive memory reads and writes from the sequencer state
	always_comb begin
		vl_we = 1'b0; vl_re = 1'b0; vl_addr = slot_idx;
		vl_wd = VALUE_BITS'(v_q);
		nx_we = 1'b0; nx_re = 1'b0; nx_wa = slot_idx; nx_ra = slot_idx; nx_wd = NONE_LINK;
		pv_we = 1'b0; pv_re = 1'b0; pv_wa = slot_idx; pv_ra = slot_idx; pv_wd = NONE_LINK;
		case (state_q)
			S_DECIDE: begin
				if (act_q == dll_pkg::ACT_INS_AFTER) begin
					nx_re = 1'b1;
					nx_ra = h_ext[SLOT_W-1:0];
				end else begin
					nx_re = 1'b1;
					pv_re = 1'b1;
					nx_ra = sel_slot[SLOT_W-1:0];
					pv_ra = sel_slot[SLOT_W-1:0];
				end
			end
			S_WNEW: begin
				vl_we = 1'b1;
				nx_we = 1'b1;
				pv_we = 1'b1;
				case (act_q)
					dll_pkg::ACT_INS_FRONT: begin
						nx_wd = head_q;
						pv_wd = NONE_LINK;
					end
					dll_pkg::ACT_INS_END: begin
						nx_wd = NONE_LINK;
						pv_wd = tail_q;
					end
					default: begin
						nx_wd = nx_rd_q;
						pv_wd = LINK_W'(h_q);
					end
				endcase
			end
			S_WLINK: begin
				case (act_q)
					dll_pkg::ACT_INS_FRONT: begin
						pv_we = head_q < NONE_LINK;
						pv_wa = head_q[SLOT_W-1:0];
						pv_wd = slot_link;
					end
					dll_pkg::ACT_INS_END: begin
						nx_we = tail_q < NONE_LINK;
						nx_wa = tail_q[SLOT_W-1:0];
						nx_wd = slot_link;
					end
					default: begin
						nx_we = 1'b1;
						nx_wa = h_ext[SLOT_W-1:0];
						nx_wd = slot_link;
						pv_we = link_q < NONE_LINK;
						pv_wa = link_q[SLOT_W-1:0];
						pv_wd = slot_link;
					end
				endcase
			end
			S_UNLINK: begin
				nx_we = pv_rd_q < NONE_LINK;
				nx_wa = pv_rd_q[SLOT_W-1:0];
				nx_wd = nx_rd_q;
				pv_we = nx_rd_q < NONE_LINK;
				pv_wa = nx_rd_q[SLOT_W-1:0];
				pv_wd = pv_rd_q;
			end
			S_TCHECK: begin
				vl_re = 1'b1;
				nx_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Node memories with registered reads
	always_ff @(posedge clk) begin
		if (vl_we) val_mem[vl_addr] <= vl_wd;
		if (vl_re) vl_rd_q <= val_mem[vl_addr];
		if (nx_we) nx_mem[nx_wa] <= nx_wd;
		if (nx_re) nx_rd_q <= nx_mem[nx_ra];
		if (pv_we) pv_mem[pv_wa] <= pv_wd;
		if (pv_re) pv_rd_q <= pv_mem[pv_ra];
	end

	// Sequencer, list state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			act_q        <= dll_pkg::ACT_INS_FRONT;
			h_q          <= '0;
			v_q          <= '0;
			slot_q       <= '0;
			link_q       <= '0;
			k_q          <= '0;
			used_q       <= '0;
			head_q       <= NONE_LINK;
			tail_q       <= NONE_LINK;
			count_q      <= '0;
			rep_handle_q <= '0;
			rep_status_q <= dll_pkg::STAT_OK;
			out_valid_q  <= 1'b0;
			out_handle_q <= '0;
			out_value_q  <= '0;
			out_status_q <= dll_pkg::STAT_OK;
			out_head_q   <= '0;
			out_tail_q   <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// Raise the output on a load, drop it once its transfer completes
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						act_q   <= dll_pkg::action_t'(s_axis_tuser);
						h_q     <= s_axis_tdata[4:0];
						v_q     <= s_axis_tdata[36:5];
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rep_handle_q <= RH_W'(POOL_NODES);
					state_q      <= S_REPORT;
					case (act_q)
						dll_pkg::ACT_INS_FRONT, dll_pkg::ACT_INS_END: begin
							if (!free_found) begin
								rep_status_q <= dll_pkg::STAT_FULL;
							end else begin
								slot_q  <= CMP_W'(free_slot);
								state_q <= S_WNEW;
							end
						end
						dll_pkg::ACT_INS_AFTER: begin
							if (!slot_live(h_ext, used_q)) begin
								rep_status_q <= dll_pkg::STAT_BAD_HANDLE;
							end else if (!free_found) begin
								rep_status_q <= dll_pkg::STAT_FULL;
							end else begin
								slot_q  <= CMP_W'(free_slot);
								state_q <= S_WNEW;
							end
						end
						dll_pkg::ACT_DEL_FRONT, dll_pkg::ACT_DEL_END,
						dll_pkg::ACT_DEL_NODE: begin
							if (list_empty) begin
								rep_status_q <= dll_pkg::STAT_EMPTY;
							end else if (!slot_live(sel_slot, used_q)) begin
								rep_status_q <= dll_pkg::STAT_BAD_HANDLE;
							end else begin
								slot_q  <= sel_slot;
								state_q <= S_UNLINK;
							end
						end
						dll_pkg::ACT_TRAVERSE: begin
							if (list_empty) begin
								rep_status_q <= dll_pkg::STAT_EMPTY;
							end else begin
								slot_q  <= CMP_W'(head_q);
								k_q     <= '0;
								state_q <= S_TCHECK;
							end
						end
						default: begin
							rep_status_q <= dll_pkg::STAT_OK;
						end
					endcase
				end
				S_WNEW: begin
					used_q[slot_idx] <= 1'b1;
					count_q          <= count_q + LINK_W'(1);
					link_q           <= nx_rd_q;
					state_q          <= S_WLINK;
				end
				S_WLINK: begin
					case (act_q)
						dll_pkg::ACT_INS_FRONT: begin
							if (head_q >= NONE_LINK) tail_q <= slot_link;
							head_q <= slot_link;
						end
						dll_pkg::ACT_INS_END: begin
							if (tail_q >= NONE_LINK) head_q <= slot_link;
							tail_q <= slot_link;
						end
						default: begin
							if (link_q >= NONE_LINK) tail_q <= slot_link;
						end
					endcase
					rep_handle_q <= RH_W'(slot_q);
					rep_status_q <= dll_pkg::STAT_OK;
					state_q      <= S_REPORT;
				end
				S_UNLINK: begin
					if (pv_rd_q >= NONE_LINK) head_q <= nx_rd_q;
					if (nx_rd_q >= NONE_LINK) tail_q <= pv_rd_q;
					used_q[slot_idx] <= 1'b0;
					count_q          <= count_q - LINK_W'(1);
					rep_handle_q     <= RH_W'(slot_q);
					rep_status_q     <= dll_pkg::STAT_OK;
					state_q          <= S_REPORT;
				end
				S_REPORT: begin
					if (out_free) begin
						out_handle_q <= rep_handle_q;
						out_value_q  <= '0;
						out_status_q <= rep_status_q;
						out_head_q   <= RH_W'(head_q);
						out_tail_q   <= RH_W'(tail_q);
						out_count_q  <= RH_W'(count_q);
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_TCHECK: begin
					// Stop the walk on a slot that is not in use
					state_q <= slot_live(slot_q, used_q) ? S_TEMIT : S_IDLE;
				end
				S_TEMIT: begin
					if (out_free) begin
						out_handle_q <= RH_W'(slot_q);
						out_value_q  <= dll_pkg::VALUE_W'(vl_rd_q);
						out_status_q <= dll_pkg::STAT_OK;
						out_head_q   <= RH_W'(head_q);
						out_tail_q   <= RH_W'(tail_q);
						out_count_q  <= RH_W'(count_q);
						out_last_q   <= trav_fin;
						if (trav_fin) begin
							state_q <= S_IDLE;
						end else begin
							slot_q  <= CMP_W'(nx_rd_q);
							k_q     <= k_q + SLOT_W'(1);
							state_q <= S_TCHECK;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Stream ports
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_count_q, out_tail_q, out_head_q, out_value_q, out_handle_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// The used bits always agree with the node count
	a_count_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("used bits disagree with node count");

	// Between actions an empty list has no head and no tail
	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		((count_q == '0) == ((head_q == NONE_LINK) && (tail_q == NONE_LINK))))
		else $error("head, tail and count out of step");

	// An accepted item blocks the input while it is processed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while an action is in progress");

endmodule

`default_nettype wire

// ----- hw/rtl/dll_free_finder.sv -----
// Lowest free pool slot search as a registered two-level priority tree.
`default_nettype none

module dll_free_finder #(
	parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
	localparam int SLOT_W = $clog2(POOL_NODES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [POOL_NODES-1:0] used,
	output logic                   found,
	output logic [SLOT_W-1:0]      slot
);

	localparam int GROUP_W = 8;
	localparam int IDX_W   = $clog2(GROUP_W);
	localparam int GROUPS  = (POOL_NODES + GROUP_W - 1) / GROUP_W;
	localparam int PAD_W   = GROUPS * GROUP_W;

	logic [PAD_W-1:0]  used_pad;
	logic [GROUPS-1:0] grp_any;
	logic [IDX_W-1:0]  grp_idx [GROUPS];
	logic [GROUPS-1:0] any_s1;
	logic [IDX_W-1:0]  idx_s1 [GROUPS];

	// Mark padding slots past the pool as taken
	always_comb begin
		used_pad = '1;
		used_pad[POOL_NODES-1:0] = used;
	end

	// Find the lowest free slot inside each group
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_any[g] = ~&used_pad[g*GROUP_W +: GROUP_W];
			grp_idx[g] = '0;
			for (int b = GROUP_W - 1; b >= 0; b--) begin
				if (!used_pad[g*GROUP_W + b]) begin
					grp_idx[g] = IDX_W'(b);
				end
			end
		end
	end

	// Register the per-group results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s1 <= '0;
			for (int g = 0; g < GROUPS; g++) begin
				idx_s1[g] <= '0;
			end
		end else begin
			any_s1 <= grp_any;
			for (int g = 0; g < GROUPS; g++) begin
				idx_s1[g] <= grp_idx[g];
			end
		end
	end

	// Pick the lowest group that has a free slot
	always_comb begin
		found = 1'b0;
		slot  = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				found = 1'b1;
				slot  = SLOT_W'(g * GROUP_W + int'(idx_s1[g]));
			end
		end
	end

endmodule

`default_nettype wire

// ----- tb/doubly_linked_list_engine_unit_tb.sv -----
// Self-checking testbench for the doubly linked list engine: directed table, then random phases.
`timescale 1ns / 1ps

module doubly_linked_list_engine_unit_tb;
	import dll_pkg::*;

	localparam logic [5:0] NO_SLOT = 6'd32;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
	localparam int N_DIRECTED = 25;

	typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_mode_t;

	// One result as it leaves the block
	typedef struct packed {
		logic [5:0]  rhandle;
		logic [31:0] rvalue;
		status_t     status;
		logic [5:0]  head;
		logic [5:0]  tail;
		logic [5:0]  count;
		logic        last;
	} list_result_t;

	// One stimulus row; typed rows carry a single-result expectation of their own
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [4:0]          handle;
		logic [31:0]         value;
		logic                typed;
		logic [5:0]          e_handle;
		status_t             e_status;
		logic [5:0]          e_head;
		logic [5:0]          e_tail;
		logic [5:0]          e_count;
	} list_row_t;

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [ACTION_W-1:0]    s_axis_tuser;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;

	// Shadow copy of the list
	logic [31:0] mdl_value [32];
	logic [5:0]  mdl_next [32];
	logic [5:0]  mdl_prev [32];
	logic [31:0] mdl_used = '0;
	logic [5:0]  mdl_head = NO_SLOT;
	logic [5:0]  mdl_tail = NO_SLOT;
	logic [5:0]  mdl_count = '0;

	list_result_t awaited_results[$];

	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_stall_left = 0;

	list_row_t directed_rows [N_DIRECTED] = '{
		// empty list: every delete and traverse reports empty, insert after a bad handle, an unused code
		'{ACT_DEL_FRONT, 5'd0,  32'h0000_0000, 1'b1, NO_SLOT, STAT_EMPTY, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_DEL_END,   5'd0,  32'h0000_0000, 1'b1, NO_SLOT, STAT_EMPTY, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_DEL_NODE,  5'd31, 32'h0000_0000, 1'b1, NO_SLOT, STAT_EMPTY, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_TRAVERSE,  5'd0,  32'h0000_0000, 1'b1, NO_SLOT, STAT_EMPTY, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_INS_AFTER, 5'd0,  32'h1234_5678, 1'b1, NO_SLOT, STAT_BAD_HANDLE, NO_SLOT, NO_SLOT,
			6'd0},
		'{ACT_UNUSED,    5'd31, 32'hFFFF_FFFF, 1'b1, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		// build 2,0,3,1,4 with extreme values
		'{ACT_INS_FRONT, 5'd0,  32'h7FFF_FFFF, 1'b1, 6'd0, STAT_OK, 6'd0, 6'd0, 6'd1},
		'{ACT_INS_END,   5'd0,  32'h8000_0000, 1'b1, 6'd1, STAT_OK, 6'd0, 6'd1, 6'd2},
		'{ACT_INS_FRONT, 5'd0,  32'hFFFF_FFFF, 1'b1, 6'd2, STAT_OK, 6'd2, 6'd1, 6'd3},
		'{ACT_INS_AFTER, 5'd0,  32'h0000_0000, 1'b1, 6'd3, STAT_OK, 6'd2, 6'd1, 6'd4},
		'{ACT_INS_AFTER, 5'd1,  32'h0000_0001, 1'b1, 6'd4, STAT_OK, 6'd2, 6'd4, 6'd5},
		'{ACT_TRAVERSE,  5'd0,  32'h0000_0000, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		// deleting the head moves it; stale and out-of-list handles are refused
		'{ACT_DEL_NODE,  5'd2,  32'h0000_0000, 1'b1, 6'd2, STAT_OK, 6'd0, 6'd4, 6'd4},
		'{ACT_DEL_NODE,  5'd2,  32'h0000_0000, 1'b1, NO_SLOT, STAT_BAD_HANDLE, 6'd0, 6'd4, 6'd4},
		'{ACT_DEL_NODE,  5'd31, 32'h0000_0000, 1'b1, NO_SLOT, STAT_BAD_HANDLE, 6'd0, 6'd4, 6'd4},
		'{ACT_INS_END,   5'd0,  32'h5555_5555, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_DEL_END,   5'd0,  32'h0000_0000, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_DEL_FRONT, 5'd0,  32'h0000_0000, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_INS_AFTER, 5'd3,  32'hAAAA_AAAA, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_TRAVERSE,  5'd0,  32'h0000_0000, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_DEL_NODE,  5'd0,  32'h0000_0000, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_DEL_NODE,  5'd1,  32'h0000_0000, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_DEL_END,   5'd0,  32'h0000_0000, 1'b0, NO_SLOT, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		// removing the only node empties the list
		'{ACT_DEL_FRONT, 5'd0,  32'h0000_0000, 1'b1, 6'd3, STAT_OK, NO_SLOT, NO_SLOT, 6'd0},
		'{ACT_TRAVERSE,  5'd0,  32'h0000_0000, 1'b1, NO_SLOT, STAT_EMPTY, NO_SLOT, NO_SLOT, 6'd0}
	};

	doubly_linked_list_engine_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: worst case is ~320 items with up to 32 results each, about 4.3 ms
	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [5:0] lowest_free_slot();
		for (int i = 0; i < 32; i++) begin
			if (!mdl_used[i])
				return 6'(i);
		end
		return NO_SLOT;
	endfunction

	function automatic void take_slot(input logic [5:0] slot, input logic [31:0] val,
			input logic [5:0] prv, input logic [5:0] nxt);
		mdl_value[slot[4:0]] = val;
		mdl_prev[slot[4:0]] = prv;
		mdl_next[slot[4:0]] = nxt;
		mdl_used[slot[4:0]] = 1'b1;
		mdl_count = mdl_count + 6'd1;
	endfunction

	// Head, tail and count are taken after the action has been applied
	function automatic list_result_t make_result(input logic [5:0] rhandle,
			input logic [31:0] rvalue, input status_t status, input logic last);
		return '{rhandle, rvalue, status, mdl_head, mdl_tail, mdl_count, last};
	endfunction

	// Apply one action to the shadow list and return the results it produces
	function automatic void apply_list_action(input logic [ACTION_W-1:0] act,
			input logic [4:0] hnd, input logic [31:0] val, output list_result_t res[$]);
		logic [5:0] slot;
		logic [5:0] prv;
		logic [5:0] nxt;
		logic       fin;
		int         k;
		res = {};
		case (act)
			ACT_INS_FRONT, ACT_INS_END: begin
				slot = lowest_free_slot();
				if (slot == NO_SLOT) begin
					res.push_back(make_result(NO_SLOT, '0, STAT_FULL, 1'b1));
				end else if (act == ACT_INS_FRONT) begin
					take_slot(slot, val, NO_SLOT, mdl_head);
					if (mdl_head < NO_SLOT)
						mdl_prev[mdl_head[4:0]] = slot;
					else
						mdl_tail = slot;
					mdl_head = slot;
					res.push_back(make_result(slot, '0, STAT_OK, 1'b1));
				end else begin
					take_slot(slot, val, mdl_tail, NO_SLOT);
					if (mdl_tail < NO_SLOT)
						mdl_next[mdl_tail[4:0]] = slot;
					else
						mdl_head = slot;
					mdl_tail = slot;
					res.push_back(make_result(slot, '0, STAT_OK, 1'b1));
				end
			end
			ACT_INS_AFTER: begin
				// handle check comes before the full check
				slot = lowest_free_slot();
				if (!mdl_used[hnd]) begin
					res.push_back(make_result(NO_SLOT, '0, STAT_BAD_HANDLE, 1'b1));
				end else if (slot == NO_SLOT) begin
					res.push_back(make_result(NO_SLOT, '0, STAT_FULL, 1'b1));
				end else begin
					nxt = mdl_next[hnd];
					take_slot(slot, val, {1'b0, hnd}, nxt);
					if (nxt < NO_SLOT)
						mdl_prev[nxt[4:0]] = slot;
					else
						mdl_tail = slot;
					mdl_next[hnd] = slot;
					res.push_back(make_result(slot, '0, STAT_OK, 1'b1));
				end
			end
			ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_NODE: begin
				if (act == ACT_DEL_FRONT)
					slot = mdl_head;
				else if (act == ACT_DEL_END)
					slot = mdl_tail;
				else
					slot = {1'b0, hnd};
				if (mdl_count == 0 || mdl_head >= NO_SLOT) begin
					res.push_back(make_result(NO_SLOT, '0, STAT_EMPTY, 1'b1));
				end else if (slot >= NO_SLOT || !mdl_used[slot[4:0]]) begin
					res.push_back(make_result(NO_SLOT, '0, STAT_BAD_HANDLE, 1'b1));
				end else begin
					// unlink, patching neighbors or head and tail
					prv = mdl_prev[slot[4:0]];
					nxt = mdl_next[slot[4:0]];
					if (prv < NO_SLOT)
						mdl_next[prv[4:0]] = nxt;
					else
						mdl_head = nxt;
					if (nxt < NO_SLOT)
						mdl_prev[nxt[4:0]] = prv;
					else
						mdl_tail = prv;
					mdl_used[slot[4:0]] = 1'b0;
					mdl_count = mdl_count - 6'd1;
					res.push_back(make_result(slot, '0, STAT_OK, 1'b1));
				end
			end
			ACT_TRAVERSE: begin
				if (mdl_count == 0 || mdl_head >= NO_SLOT) begin
					res.push_back(make_result(NO_SLOT, '0, STAT_EMPTY, 1'b1));
				end else begin
					// walk head to tail, bounded by the pool size
					slot = mdl_head;
					k = 0;
					while (k < 32 && slot < NO_SLOT && mdl_used[slot[4:0]]) begin
						nxt = mdl_next[slot[4:0]];
						fin = (nxt >= NO_SLOT) || (k + 1 >= 32);
						res.push_back(make_result(slot, mdl_value[slot[4:0]], STAT_OK, fin));
						k++;
						if (fin)
							break;
						slot = nxt;
					end
				end
			end
			default: begin
				res.push_back(make_result(NO_SLOT, '0, STAT_OK, 1'b1));
			end
		endcase
	endfunction

	// Random slot among those in the list; any slot when the list is empty
	function automatic logic [4:0] pick_used_slot();
		int r;
		if (mdl_count == 0)
			return 5'($urandom_range(0, 31));
		r = $urandom_range(0, mdl_count - 1);
		for (int i = 0; i < 32; i++) begin
			if (mdl_used[i]) begin
				if (r == 0)
					return 5'(i);
				r--;
			end
		end
		return '0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Present one item and hold it until the transfer, then queue its expectations
	task automatic drive_item(input list_row_t row);
		list_result_t res[$];
		s_axis_tdata <= {3'b000, row.value, row.handle};
		s_axis_tuser <= row.action;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		apply_list_action(row.action, row.handle, row.value, res);
		if (row.typed)
			awaited_results.push_back('{row.e_handle, 32'd0, row.e_status, row.e_head,
				row.e_tail, row.e_count, 1'b1});
		else
			foreach (res[i])
				awaited_results.push_back(res[i]);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	// Hold off the sender until every awaited result has come back
	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// Random phase: the mode sets how strongly the list grows or shrinks
	task automatic run_phase(input phase_mode_t mode, input int n_items);
		list_row_t row;
		int roll;
		int ins_pct;
		case (mode)
			PH_GROW:  ins_pct = 70;
			PH_MIXED: ins_pct = 42;
			default:  ins_pct = 15;
		endcase
		for (int i = 0; i < n_items; i++) begin
			row = '0;
			row.value = $urandom();
			row.handle = 5'($urandom_range(0, 31));
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				row.action = 3'($urandom_range(ACT_INS_FRONT, ACT_INS_AFTER));
			else if (roll < 88)
				row.action = 3'($urandom_range(ACT_DEL_FRONT, ACT_DEL_NODE));
			else if (roll < 98)
				row.action = ACT_TRAVERSE;
			else
				row.action = ACT_UNUSED;
			// aim most handle-based actions at live nodes
			if ((row.action == ACT_INS_AFTER || row.action == ACT_DEL_NODE)
					&& $urandom_range(0, 99) < 85)
				row.handle = pick_used_slot();
			drive_item(row);
		end
	endtask

	// Result side: check transfers, then pick the next ready level
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[5:0], m_axis_tdata[37:6], status_t'(m_axis_tuser),
				m_axis_tdata[43:38], m_axis_tdata[49:44], m_axis_tdata[55:50], m_axis_tlast};
			results_checked++;
			status_seen[got.status]++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result with none awaited, handle %0d", got.rhandle));
			end else begin
				want = awaited_results.pop_front();
				check_field("result_handle", got.rhandle, want.rhandle);
				check_field("result_value", got.rvalue, want.rvalue);
				check_field("status", got.status, want.status);
				check_field("head_handle", got.head, want.head);
				check_field("tail_handle", got.tail, want.tail);
				check_field("node_count", got.count, want.count);
				check_field("last", got.last, want.last);
			end
		end
		if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left--;
		end else if ($urandom_range(0, 99) < rx_idle_pct) begin
			m_axis_tready <= 1'b0;
			rx_stall_left = pick_gap() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Main sequence
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		foreach (directed_rows[i])
			drive_item(directed_rows[i]);
		pause_until_drained();

		// random phases, with different idle rates on the sending and receiving sides
		tx_idle_pct = 0;  rx_idle_pct = 0;  run_phase(PH_GROW, 49);
		pause_until_drained();
		tx_idle_pct = 40; rx_idle_pct = 40; run_phase(PH_MIXED, 49);
		tx_idle_pct = 20; rx_idle_pct = 50; run_phase(PH_SHRINK, 49);
		pause_until_drained();
		tx_idle_pct = 50; rx_idle_pct = 10; run_phase(PH_GROW, 49);
		tx_idle_pct = 0;  rx_idle_pct = 60; run_phase(PH_MIXED, 49);
		pause_until_drained();
		tx_idle_pct = 30; rx_idle_pct = 0;  run_phase(PH_SHRINK, 49);

		// wait out the remaining results, then leave time for strays
		pause_until_drained();
		repeat (20) @(posedge clk);

		$display("run: %0d actions sent, %0d results checked, %0d mismatches",
			items_sent, results_checked, mismatches);
		$display("statuses seen: ok %0d, pool full %0d, list empty %0d, bad handle %0d",
			status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
			status_seen[STAT_BAD_HANDLE]);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
